/* hw/rtl/trace_noise_uptime_tracker_defines.svh */
// ----------------------------------------------------------------------------
// Trace noise uptime tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRACE_NOISE_UPTIME_TRACKER_DEFINES_SVH
`define TRACE_NOISE_UPTIME_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TNUT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tracker check failed");

// The consequent must hold in the cycle after the antecedent.
`define TNUT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tracker check failed");

`endif

/* hw/rtl/tnut_pkg.sv */
// ----------------------------------------------------------------------------
// Trace noise uptime tracker package
// Record and table entry types, register indexes and reset values.
// ----------------------------------------------------------------------------
package tnut_pkg;

	localparam logic [1:0] CFG_VARIANCE_LIMIT = 2'd0;
	localparam logic [1:0] CFG_MEAN_LIMIT     = 2'd1;
	localparam logic [1:0] CFG_GAP_SECONDS    = 2'd2;
	localparam logic [1:0] CFG_MARGIN_SECONDS = 2'd3;

	localparam logic [15:0] VARIANCE_LIMIT_RST = 16'd100;
	localparam logic [14:0] MEAN_LIMIT_RST     = 15'd100;
	localparam logic [15:0] GAP_SECONDS_RST    = 16'd20;
	localparam logic [15:0] MARGIN_SECONDS_RST = 16'd10;

	localparam logic REC_ACTIVE = 1'b0;
	localparam logic REC_GAP    = 1'b1;

	localparam logic [1:0] FLAGS_BOTH_GOOD = 2'b11;

	typedef struct packed {
		logic [30:0] first_sec;
		logic [30:0] last_sec;
		logic [1:0]  flags;
	} entry_t;

	typedef struct packed {
		logic [7:0]  station;
		logic        kind;
		logic [30:0] from_sec;
		logic [30:0] to_sec;
		logic        good_first;
		logic        good_second;
		logic        last;
	} record_t;

endpackage

/* hw/rtl/tnut_mul.sv */
// ----------------------------------------------------------------------------
// Trace noise uptime tracker shift-add multiplier
// Serial multiplier: one add of the shifted multiplicand per set multiplier bit.
// ----------------------------------------------------------------------------
module tnut_mul #(
	parameter int XW = 56,
	parameter int YW = 28
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [XW-1:0] x,
	input  logic [YW-1:0] y,
	output logic          done,
	output logic [XW-1:0] product
);

	logic          busy_q;
	logic [XW-1:0] acc_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (y_q == '0)) begin
			busy_q <= 1'b0;
		end
	end

	// The loop stops as soon as no multiplier bits remain.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (busy_q && (y_q != '0)) begin
			if (y_q[0]) begin
				acc_q <= acc_q + x_q;
			end
			x_q <= {x_q[XW-2:0], 1'b0};
			y_q <= {1'b0, y_q[YW-1:1]};
		end
	end

	assign done    = busy_q && (y_q == '0);
	assign product = acc_q;

endmodule

/* hw/rtl/tnut_table.sv */
// ----------------------------------------------------------------------------
// Trace noise uptime tracker station table
// Per-station interval memory with a valid bit for each entry.
// ----------------------------------------------------------------------------
module tnut_table #(
	parameter int DEPTH = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	output tnut_pkg::entry_t          rd_entry,
	output logic                      rd_valid,
	input  logic                      wr_en,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  tnut_pkg::entry_t          wr_entry
);

	tnut_pkg::entry_t mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	tnut_pkg::entry_t rd_entry_q;
	logic             rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem[rd_addr];
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_valid = rd_valid_q;

endmodule

/* hw/rtl/trace_noise_uptime_tracker.sv */
// ----------------------------------------------------------------------------
// Trace noise uptime tracker
// Judges ADC trace noise per channel and keeps per-station uptime intervals.
// ----------------------------------------------------------------------------
// A sample that does not end a trace leaves the block ready again in the next
// cycle. A sample that ends a trace starts an evaluation on one shared
// shift-add multiplier, which forms n*sum_sq, sum*sum, n*n,
// variance_limit*n*n and mean_limit*n in turn; each product takes one step
// per bit of its multiplier operand up to the highest set bit, and no sample
// is accepted until the evaluation and any record output are finished.
// After the second channel's trace, a decide step updates the station table
// and each emitted record is loaded into the output register, waiting there
// while out_ready is low. The table has a valid bit for each station, so there
// is no clearing pass after reset.
module trace_noise_uptime_tracker #(
	parameter int STATIONS  = 256,
	parameter int MAX_TRACE = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         station,
	input  logic               channel,
	input  logic signed [15:0] sample,
	input  logic [30:0]        gps_seconds,
	input  logic               last_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_station,
	output logic               record_kind,
	output logic [30:0]        from_seconds,
	output logic [30:0]        to_seconds,
	output logic               good_first,
	output logic               good_second,
	output logic               last_record
);

	localparam int CW  = $clog2(MAX_TRACE + 1);
	localparam int SW  = CW + 16;
	localparam int AW  = CW + 15;
	localparam int QW  = CW + 30;
	localparam int PW  = 2 * CW + 30;
	localparam int SIW = $clog2(STATIONS);
	localparam logic [8:0]    ST_LIMIT  = 9'(STATIONS);
	localparam logic [CW-1:0] TRACE_MAX = CW'(MAX_TRACE);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_NSQ    = 10'b0000000010,
		ST_AA     = 10'b0000000100,
		ST_NN     = 10'b0000001000,
		ST_VNN    = 10'b0000010000,
		ST_MN     = 10'b0000100000,
		ST_DECIDE = 10'b0001000000,
		ST_EMIT0  = 10'b0010000000,
		ST_EMIT1  = 10'b0100000000,
		ST_SPARE  = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [15:0] var_limit_q;
	logic [14:0] mean_limit_q;
	logic [15:0] gap_q;
	logic [15:0] margin_q;

	logic                 started_q;
	logic [30:0]          start_q;
	logic signed [SW-1:0] sum_q;
	logic [QW-1:0]        sq_q;
	logic [CW-1:0]        count_q;
	logic                 first_good_q;

	logic          launch_q;
	logic [PW-1:0] p1_q;
	logic [PW-1:0] spread_q;
	logic [2*CW-1:0] nn_q;
	logic          quiet_q;
	logic          ch_q;
	logic [7:0]    st_q;
	logic [30:0]   t_q;
	logic [1:0]    newflags_q;
	logic          gap_pending_q;
	tnut_pkg::record_t rec0_q;
	tnut_pkg::record_t rec1_q;
	tnut_pkg::record_t out_q;
	logic          out_valid_q;

	logic                 in_xfer;
	logic signed [31:0]   sq_term;
	logic [SW-1:0]        sum_neg;
	logic [AW-1:0]        mag;
	logic                 mul_done;
	logic [PW-1:0]        mul_x;
	logic [AW-1:0]        mul_y;
	logic [PW-1:0]        mul_p;
	logic                 good;
	logic                 in_range;
	logic                 out_free;

	logic                 tbl_rd_en;
	tnut_pkg::entry_t     tbl_rd_entry;
	logic                 tbl_rd_valid;
	logic                 tbl_wr_en;
	tnut_pkg::entry_t     tbl_wr_entry;

	logic [30:0]          ent_first;
	logic [30:0]          ent_last;
	logic [1:0]           ent_flags;
	logic [1:0]           f_eff;
	logic [31:0]          dt;
	logic [31:0]          gap_from;
	logic [31:0]          gap_to;
	logic                 gap_hit;
	logic                 margin_hit;
	logic                 close_iv;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign sq_term  = sample * sample;
	assign sum_neg  = -sum_q;
	assign mag      = AW'(sum_q[SW-1] ? sum_neg : sum_q);
	assign in_range = ({1'b0, st_q} < ST_LIMIT);
	assign out_free = !out_valid_q || out_ready;
	assign good     = !quiet_q && !(PW'(mag) > mul_p);

	always_comb begin
		mul_x = PW'(sq_q);
		mul_y = AW'(count_q);
		case (state_q)
			ST_NSQ: begin
				mul_x = PW'(sq_q);
				mul_y = AW'(count_q);
			end
			ST_AA: begin
				mul_x = PW'(mag);
				mul_y = mag;
			end
			ST_NN: begin
				mul_x = PW'(count_q);
				mul_y = AW'(count_q);
			end
			ST_VNN: begin
				mul_x = PW'(nn_q);
				mul_y = AW'(var_limit_q);
			end
			ST_MN: begin
				mul_x = PW'(mean_limit_q);
				mul_y = AW'(count_q);
			end
			default: begin
				mul_x = PW'(sq_q);
				mul_y = AW'(count_q);
			end
		endcase
	end

	tnut_mul #(
		.XW(PW),
		.YW(AW)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (launch_q),
		.x       (mul_x),
		.y       (mul_y),
		.done    (mul_done),
		.product (mul_p)
	);

	assign tbl_rd_en = (state_q == ST_MN) && mul_done && ch_q && in_range;

	// An entry never written stands for an interval at the first event time.
	always_comb begin
		if (tbl_rd_valid) begin
			ent_first = tbl_rd_entry.first_sec;
			ent_last  = tbl_rd_entry.last_sec;
			ent_flags = tbl_rd_entry.flags;
		end else begin
			ent_first = start_q;
			ent_last  = start_q;
			ent_flags = tnut_pkg::FLAGS_BOTH_GOOD;
		end
		f_eff      = (ent_last == start_q) ? newflags_q : ent_flags;
		dt         = {1'b0, t_q} - {1'b0, ent_last};
		gap_hit    = $signed(dt) > $signed({16'd0, gap_q});
		margin_hit = $signed(dt) > $signed({16'd0, margin_q});
		close_iv   = gap_hit || (f_eff != newflags_q);
		gap_from   = {1'b0, ent_last} + {16'd0, margin_q};
		gap_to     = {1'b0, t_q} - {16'd0, margin_q};
		tbl_wr_en  = (state_q == ST_DECIDE);
		if (close_iv) begin
			tbl_wr_entry = '{first_sec: t_q, last_sec: t_q, flags: newflags_q};
		end else begin
			tbl_wr_entry = '{first_sec: ent_first, last_sec: t_q, flags: f_eff};
		end
	end

	tnut_table #(
		.DEPTH(STATIONS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (tbl_rd_en),
		.rd_addr  (st_q[SIW-1:0]),
		.rd_entry (tbl_rd_entry),
		.rd_valid (tbl_rd_valid),
		.wr_en    (tbl_wr_en),
		.wr_addr  (st_q[SIW-1:0]),
		.wr_entry (tbl_wr_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_limit_q  <= tnut_pkg::VARIANCE_LIMIT_RST;
			mean_limit_q <= tnut_pkg::MEAN_LIMIT_RST;
			gap_q        <= tnut_pkg::GAP_SECONDS_RST;
			margin_q     <= tnut_pkg::MARGIN_SECONDS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tnut_pkg::CFG_VARIANCE_LIMIT: var_limit_q  <= cfg_data;
				tnut_pkg::CFG_MEAN_LIMIT:     mean_limit_q <= cfg_data[14:0];
				tnut_pkg::CFG_GAP_SECONDS:    gap_q        <= cfg_data;
				tnut_pkg::CFG_MARGIN_SECONDS: margin_q     <= cfg_data;
				default:                      gap_q        <= gap_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			launch_q      <= 1'b0;
			started_q     <= 1'b0;
			start_q       <= '0;
			sum_q         <= '0;
			sq_q          <= '0;
			count_q       <= '0;
			first_good_q  <= 1'b1;
			gap_pending_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (!started_q) begin
							started_q <= 1'b1;
							start_q   <= gps_seconds;
						end
						if (count_q < TRACE_MAX) begin
							sum_q   <= sum_q + SW'(sample);
							sq_q    <= sq_q + QW'(sq_term[30:0]);
							count_q <= count_q + 1'b1;
						end
						if (last_sample) begin
							state_q  <= ST_NSQ;
							launch_q <= 1'b1;
						end
					end
				end
				ST_NSQ: begin
					if (mul_done) begin
						state_q  <= ST_AA;
						launch_q <= 1'b1;
					end
				end
				ST_AA: begin
					if (mul_done) begin
						state_q  <= ST_NN;
						launch_q <= 1'b1;
					end
				end
				ST_NN: begin
					if (mul_done) begin
						state_q  <= ST_VNN;
						launch_q <= 1'b1;
					end
				end
				ST_VNN: begin
					if (mul_done) begin
						state_q  <= ST_MN;
						launch_q <= 1'b1;
					end
				end
				ST_MN: begin
					if (mul_done) begin
						sum_q   <= '0;
						sq_q    <= '0;
						count_q <= '0;
						if (!ch_q) begin
							first_good_q <= good;
							state_q      <= ST_IDLE;
						end else begin
							first_good_q <= 1'b1;
							state_q      <= in_range ? ST_DECIDE : ST_IDLE;
						end
					end
				end
				ST_DECIDE: begin
					gap_pending_q <= margin_hit;
					state_q       <= close_iv ? ST_EMIT0 : ST_IDLE;
				end
				ST_EMIT0: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= gap_pending_q ? ST_EMIT1 : ST_IDLE;
					end
				end
				ST_EMIT1: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operand and record registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_xfer && last_sample) begin
			ch_q <= channel;
			st_q <= station;
			t_q  <= gps_seconds;
		end
		if (mul_done) begin
			case (state_q)
				ST_NSQ: p1_q <= mul_p;
				ST_AA:  spread_q <= (p1_q >= mul_p) ? (p1_q - mul_p) : '0;
				ST_NN:  nn_q <= mul_p[2*CW-1:0];
				ST_VNN: quiet_q <= (spread_q < mul_p);
				ST_MN:  newflags_q <= {first_good_q, good};
				default: p1_q <= p1_q;
			endcase
		end
		if (state_q == ST_DECIDE) begin
			rec0_q <= '{station: st_q, kind: tnut_pkg::REC_ACTIVE, from_sec: ent_first,
				to_sec: ent_last, good_first: f_eff[1], good_second: f_eff[0],
				last: !margin_hit};
			rec1_q <= '{station: st_q, kind: tnut_pkg::REC_GAP, from_sec: gap_from[30:0],
				to_sec: gap_to[30:0], good_first: 1'b0, good_second: 1'b0, last: 1'b1};
		end
		if ((state_q == ST_EMIT0) && out_free) begin
			out_q <= rec0_q;
		end else if ((state_q == ST_EMIT1) && out_free) begin
			out_q <= rec1_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_station  = out_q.station;
	assign record_kind  = out_q.kind;
	assign from_seconds = out_q.from_sec;
	assign to_seconds   = out_q.to_sec;
	assign good_first   = out_q.good_first;
	assign good_second  = out_q.good_second;
	assign last_record  = out_q.last;

endmodule

/* hw/rtl/tnut_checker.sv */
// ----------------------------------------------------------------------------
// Trace noise uptime tracker port checker
// Concurrent checks on the top level ports, attached by bind.
// ----------------------------------------------------------------------------
`include "trace_noise_uptime_tracker_defines.svh"

module tnut_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        last_sample,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_station,
	input logic        record_kind,
	input logic [30:0] from_seconds,
	input logic [30:0] to_seconds,
	input logic        good_first,
	input logic        good_second,
	input logic        last_record
);

	// A stalled record keeps its contents.
	`TNUT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_station) && $stable(from_seconds) && $stable(to_seconds) && $stable(record_kind))

	// A transfer that does not end a trace leaves the block ready.
	`TNUT_ASSERT_NEXT(a_sample_stream, in_valid && in_ready && !last_sample, in_ready)

	// The end of a trace always starts an evaluation.
	`TNUT_ASSERT_NEXT(a_trace_end_busy, in_valid && in_ready && last_sample, !in_ready)

	// A gap record carries no flags and always closes its group.
	`TNUT_ASSERT_NOW(a_gap_record, out_valid && (record_kind == tnut_pkg::REC_GAP), last_record && !good_first && !good_second)

endmodule

bind trace_noise_uptime_tracker tnut_checker u_tnut_checker (.*);
